// ===== rtl/assert_macros.svh =====
// Assertion macros for the stack machine execute unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/smx_pkg.sv =====
// Types and codes shared by the stack machine execute unit.
package smx_pkg;
    typedef enum logic [4:0] {
        OP_PUSH = 5'd0, OP_DUP = 5'd1, OP_POP = 5'd2, OP_RET = 5'd3, OP_POPN = 5'd4,
        OP_JMP = 5'd5, OP_JEZ = 5'd6, OP_JNZ = 5'd7, OP_INC = 5'd8, OP_DEC = 5'd9,
        OP_ADD = 5'd10, OP_SUB = 5'd11, OP_MUL = 5'd12, OP_DIV = 5'd13,
        OP_AND = 5'd14, OP_OR = 5'd15, OP_XOR = 5'd16, OP_NOT = 5'd17
    } t_op;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNDER    = 3'd1;
    localparam logic [2:0] ST_OVER     = 3'd2;
    localparam logic [2:0] ST_NOTNUM   = 3'd3;
    localparam logic [2:0] ST_DIVZERO  = 3'd4;
    localparam logic [2:0] ST_BADCOUNT = 3'd5;
    localparam logic [2:0] ST_HALTED   = 3'd6;

    typedef struct packed {
        logic [4:0]         op;
        logic signed [31:0] operand_value;
        logic               operand_is_number;
        logic [7:0]         jump_target;
    } t_instr;

    typedef struct packed {
        logic [2:0]         status;
        logic               branch_taken;
        logic [7:0]         branch_target;
        logic               halted;
        logic signed [31:0] return_value;
        logic               return_is_number;
        logic [8:0]         stack_depth;
    } t_result;
endpackage

// ===== rtl/smx_if.sv =====
// Valid/ready channel carrying one word of type T.
interface smx_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/stack_machine_execute_unit.sv =====
// Stack machine execute unit: operand stack memory and a shared multi-cycle ALU.
//
// Usage: instructions arrive on i_instr (op, constant, tag, jump target), one
// result word per instruction leaves on o_result. An instruction is taken when
// valid and ready are high; ready is low while one is in flight.
// The top two stack entries are read in S_RD1 and S_RD2 after the word is
// taken (one memory read port, registered data); the result word is set in S_EXEC
// for most ops, and at the end of S_ITER for mul (shift-add) and div (restoring),
// which iterate on one shared adder. A result then waits in the output register;
// the unit goes back to idle, and takes the next instruction, only once the
// result is taken, so no new instruction is taken while one is in flight.
// Reset clears the stack pointer and halt flag; stack contents are undefined
// until pushed. When the receiver stalls the result holds and the unit stays
// not ready. After a ret that does not underflow every instruction reports the halted status.
`include "assert_macros.svh"
module stack_machine_execute_unit import smx_pkg::*; #(
    parameter int STACK_DEPTH = 256
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    smx_if.sink    i_instr,
    smx_if.source  o_result
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_EXEC, S_ITER, S_DONE} t_state;

    logic [32:0]   r_mem [STACK_DEPTH];
    logic [32:0]   r_rdata;
    logic [AW-1:0] r_raddr;
    logic          r_we;
    logic [AW-1:0] r_waddr;
    logic [32:0]   r_wdata;

    t_state        r_state;
    t_instr        r_in;
    t_result       r_res;
    logic [PW-1:0] r_sp;
    logic          r_halt;
    logic          r_valid;
    logic [32:0]   r_top;
    // iterative unit
    logic [5:0]    r_cnt;
    logic [31:0]   r_acc, r_q, r_d;
    logic          r_neg;

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdata;
        r_rdata <= r_mem[r_raddr];
    end

    logic [PW-1:0] sp_m1, sp_m2;
    assign sp_m1 = r_sp - PW'(1);
    assign sp_m2 = r_sp - PW'(2);

    logic [31:0] b, abs_b;
    assign b = r_top[31:0];
    assign abs_b = b[31] ? (32'd0 - b) : b;

    // shared adder: mul accumulates, div trial-subtracts
    logic        is_div;
    logic [32:0] add_a, add_b, add_s;
    assign is_div = (r_in.op == OP_DIV);
    always_comb begin
        if (is_div) begin
            add_a = {r_acc, r_q[31]};
            add_b = ~{1'b0, r_d} + 33'd1;
        end else begin
            add_a = {1'b0, r_acc};
            add_b = r_q[0] ? {1'b0, r_d} : 33'd0;
        end
        add_s = add_a + add_b;
    end

    logic [31:0] cnt32;
    assign cnt32 = r_in.operand_value;

    assign i_instr.ready  = (r_state == S_IDLE);
    assign o_result.valid = r_valid;
    assign o_result.data  = r_res;

    task automatic finish(input logic [2:0] st);
        r_res.status        <= st;
        r_res.halted        <= r_halt;
        r_valid             <= 1'b1;
        r_state             <= S_DONE;
    endtask

    always_ff @(posedge i_clk) begin
        r_we <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_halt  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_instr.valid) begin
                        r_in    <= i_instr.data;
                        r_raddr <= sp_m1[AW-1:0];
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_raddr <= sp_m2[AW-1:0];
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_top   <= r_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_res.branch_taken     <= 1'b0;
                    r_res.branch_target    <= '0;
                    r_res.return_value     <= '0;
                    r_res.return_is_number <= 1'b0;
                    r_res.stack_depth      <= 9'(r_sp);
                    r_res.halted           <= r_halt;
                    r_res.status           <= ST_OK;
                    r_valid                <= 1'b1;
                    r_state                <= S_DONE;
                    if (r_halt) begin
                        r_res.status <= ST_HALTED;
                    end else begin
                        case (r_in.op) inside
                            OP_PUSH, OP_DUP: begin
                                if (32'(r_sp) >= STACK_DEPTH) r_res.status <= ST_OVER;
                                else if (r_in.op == OP_DUP && r_sp == '0)
                                    r_res.status <= ST_UNDER;
                                else begin
                                    r_we    <= 1'b1;
                                    r_waddr <= r_sp[AW-1:0];
                                    r_wdata <= (r_in.op == OP_DUP) ? r_top
                                        : {r_in.operand_is_number, r_in.operand_value};
                                    r_sp    <= r_sp + PW'(1);
                                    r_res.stack_depth <= 9'(r_sp + PW'(1));
                                end
                            end
                            OP_POP, OP_RET: begin
                                if (r_sp == '0) r_res.status <= ST_UNDER;
                                else begin
                                    r_sp <= sp_m1;
                                    r_res.stack_depth <= 9'(sp_m1);
                                    if (r_in.op == OP_RET) begin
                                        r_halt <= 1'b1;
                                        r_res.halted <= 1'b1;
                                        r_res.return_value <= r_top[31:0];
                                        r_res.return_is_number <= r_top[32];
                                    end
                                end
                            end
                            OP_POPN: begin
                                if (!r_in.operand_is_number) r_res.status <= ST_NOTNUM;
                                else if (cnt32[31] || cnt32 > 32'(r_sp))
                                    r_res.status <= ST_BADCOUNT;
                                else begin
                                    r_sp <= r_sp - PW'(cnt32);
                                    r_res.stack_depth <= 9'(r_sp - PW'(cnt32));
                                end
                            end
                            OP_JMP: begin
                                r_res.branch_taken  <= 1'b1;
                                r_res.branch_target <= r_in.jump_target;
                            end
                            OP_JEZ, OP_JNZ, OP_INC, OP_DEC: begin
                                if (r_sp == '0) r_res.status <= ST_UNDER;
                                else if (r_top[32]) begin
                                    if (r_in.op == OP_JEZ || r_in.op == OP_JNZ) begin
                                        if ((b == '0) == (r_in.op == OP_JEZ)) begin
                                            r_res.branch_taken  <= 1'b1;
                                            r_res.branch_target <= r_in.jump_target;
                                        end
                                    end else begin
                                        r_we    <= 1'b1;
                                        r_waddr <= sp_m1[AW-1:0];
                                        r_wdata <= {1'b1, (r_in.op == OP_INC) ?
                                            b + 32'd1 : b - 32'd1};
                                    end
                                end
                            end
                            OP_NOT: begin
                                if (r_sp == '0) r_res.status <= ST_UNDER;
                                else if (!r_top[32]) r_res.status <= ST_NOTNUM;
                                else begin
                                    r_we    <= 1'b1;
                                    r_waddr <= sp_m1[AW-1:0];
                                    r_wdata <= {1'b1, 31'd0, b == '0};
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR: begin
                                if (r_sp < PW'(2)) r_res.status <= ST_UNDER;
                                else if (!r_top[32] || !r_rdata[32])
                                    r_res.status <= ST_NOTNUM;
                                else if (r_in.op == OP_DIV && b == '0)
                                    r_res.status <= ST_DIVZERO;
                                else if (r_in.op == OP_MUL || r_in.op == OP_DIV) begin
                                    // start the iterative unit; operand a from r_rdata
                                    r_valid <= 1'b0;
                                    r_cnt   <= 6'd32;
                                    r_acc   <= '0;
                                    r_state <= S_ITER;
                                    if (r_in.op == OP_MUL) begin
                                        r_q <= r_rdata[31:0];
                                        r_d <= b;
                                    end else begin
                                        r_q   <= r_rdata[31] ? 32'd0 - r_rdata[31:0]
                                                             : r_rdata[31:0];
                                        r_d   <= abs_b;
                                        r_neg <= r_rdata[31] ^ b[31];
                                    end
                                end else begin
                                    r_we    <= 1'b1;
                                    r_waddr <= sp_m2[AW-1:0];
                                    r_sp    <= sp_m1;
                                    r_res.stack_depth <= 9'(sp_m1);
                                    case (r_in.op)
                                        OP_ADD: r_wdata <= {1'b1, r_rdata[31:0] + b};
                                        OP_SUB: r_wdata <= {1'b1, r_rdata[31:0] - b};
                                        OP_AND: r_wdata <= {1'b1, 31'd0,
                                            (r_rdata[31:0] != '0) && (b != '0)};
                                        OP_OR:  r_wdata <= {1'b1, 31'd0,
                                            (r_rdata[31:0] != '0) || (b != '0)};
                                        default: r_wdata <= {1'b1, 31'd0,
                                            r_rdata[31:0] != b};
                                    endcase
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ITER: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (is_div) begin
                        // restoring division, one quotient bit per cycle
                        if (!add_s[32]) r_acc <= add_s[31:0];
                        else r_acc <= {r_acc[30:0], r_q[31]};
                        r_q <= {r_q[30:0], ~add_s[32]};
                    end else begin
                        // shift-add: product low word builds in r_acc
                        r_acc <= add_s[31:0];
                        r_q   <= {1'b0, r_q[31:1]};
                        r_d   <= {r_d[30:0], 1'b0};
                    end
                    if (r_cnt == 6'd1) begin
                        r_we    <= 1'b1;
                        r_waddr <= sp_m2[AW-1:0];
                        if (is_div) begin
                            r_wdata <= {1'b1, r_neg ? 32'd0 - {r_q[30:0], ~add_s[32]}
                                                   : {r_q[30:0], ~add_s[32]}};
                        end else begin
                            r_wdata <= {1'b1, add_s[31:0]};
                        end
                        r_sp <= sp_m1;
                        r_res.stack_depth <= 9'(sp_m1);
                        finish(ST_OK);
                    end
                end
                S_DONE: begin
                    if (o_result.ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLY(a_ready_idle, i_clk, i_rst_n, r_valid, !i_instr.ready)
    `ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt)
    `ASSERT_IMPLY(a_sp_range, i_clk, i_rst_n, 1'b1, 32'(r_sp) <= STACK_DEPTH)
endmodule

// ===== tb/sv/stack_machine_execute_unit_tb.sv =====
// Testbench for the stack machine execute unit: directed and random instruction streams.
`timescale 1ns / 100ps
module stack_machine_execute_unit_tb;
    import smx_pkg::*;

    localparam int DEPTH      = 256;
    localparam int MAX_CYCLES = 2000000;

    // Scoreboard: executes each accepted instruction on a private stack, queues the result.
    class exec_scoreboard;
        logic [31:0] vals [DEPTH];
        logic        tags [DEPTH];
        int unsigned sp;
        bit          halt;
        t_result     pending [$];
        int          errors;

        function new();
            sp = 0;
            halt = 0;
            errors = 0;
        endfunction

        function logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma, mb, q;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function void note_instr(t_instr ins);
            t_result     r;
            logic [31:0] a, b, x;
            r = '0;
            if (halt) begin
                r.status = ST_HALTED;
            end else begin
                case (ins.op)
                    OP_PUSH, OP_DUP: begin
                        if (sp >= DEPTH) r.status = ST_OVER;
                        else if (ins.op == OP_DUP && sp < 1) r.status = ST_UNDER;
                        else begin
                            vals[sp] = (ins.op == OP_DUP) ? vals[sp-1] : ins.operand_value;
                            tags[sp] = (ins.op == OP_DUP) ? tags[sp-1] : ins.operand_is_number;
                            sp++;
                        end
                    end
                    OP_POP, OP_RET: begin
                        if (sp < 1) r.status = ST_UNDER;
                        else begin
                            if (ins.op == OP_RET) begin
                                r.return_value = vals[sp-1];
                                r.return_is_number = tags[sp-1];
                                halt = 1;
                            end
                            sp--;
                        end
                    end
                    OP_POPN: begin
                        if (!ins.operand_is_number) r.status = ST_NOTNUM;
                        else if (ins.operand_value < 0 || ins.operand_value > sp)
                            r.status = ST_BADCOUNT;
                        else sp -= ins.operand_value;
                    end
                    OP_JMP: r.branch_taken = 1;
                    OP_JEZ, OP_JNZ, OP_INC, OP_DEC: begin
                        if (sp < 1) r.status = ST_UNDER;
                        else if (tags[sp-1]) begin
                            x = vals[sp-1];
                            case (ins.op)
                                OP_JEZ:  r.branch_taken = (x == 0);
                                OP_JNZ:  r.branch_taken = (x != 0);
                                OP_INC:  vals[sp-1] = x + 1;
                                default: vals[sp-1] = x - 1;
                            endcase
                        end
                    end
                    OP_NOT: begin
                        if (sp < 1) r.status = ST_UNDER;
                        else if (!tags[sp-1]) r.status = ST_NOTNUM;
                        else vals[sp-1] = (vals[sp-1] == 0);
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR: begin
                        if (sp < 2) r.status = ST_UNDER;
                        else if (!tags[sp-1] || !tags[sp-2]) r.status = ST_NOTNUM;
                        else begin
                            b = vals[sp-1];
                            a = vals[sp-2];
                            x = '0;
                            case (ins.op)
                                OP_ADD: x = a + b;
                                OP_SUB: x = a - b;
                                OP_MUL: x = a * b;
                                OP_DIV: if (b == 0) r.status = ST_DIVZERO;
                                        else x = div_toward_zero(a, b);
                                OP_AND: x = (a != 0 && b != 0);
                                OP_OR:  x = (a != 0 || b != 0);
                                default: x = (a != b);
                            endcase
                            if (r.status == ST_OK) begin
                                vals[sp-2] = x;
                                tags[sp-2] = 1;
                                sp--;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            r.branch_target = r.branch_taken ? ins.jump_target : 8'd0;
            r.halted = halt;
            r.stack_depth = sp[8:0];
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected st=%0d br=%0d tgt=%0d h=%0d rv=%h rt=%0d d=%0d, got st=%0d br=%0d tgt=%0d h=%0d rv=%h rt=%0d d=%0d",
                        want.status, want.branch_taken, want.branch_target, want.halted,
                        want.return_value, want.return_is_number, want.stack_depth,
                        got.status, got.branch_taken, got.branch_target, got.halted,
                        got.return_value, got.return_is_number, got.stack_depth);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   cycle_count = 0;
    bit   sink_idle_off = 0;

    smx_if #(.T(t_instr))  instr_ch ();
    smx_if #(.T(t_result)) result_ch ();

    stack_machine_execute_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_ch.sink),
        .o_result (result_ch.source)
    );

    exec_scoreboard sb = new();
    int             model_depth;   // tracked stack depth for stimulus shaping

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check each taken word (the sink below stalls at random per word)
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.data);
    end

    initial begin : result_sink
        int gap;
        result_ch.ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = (sink_idle_off || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
                result_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1;
            @(posedge i_clk iff result_ch.valid);
        end
    end

    task automatic send_instr(t_op op, logic [31:0] val, logic tag, logic [7:0] tgt,
                              bit no_gap = 0);
        t_instr ins;
        int     gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            instr_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        ins.op = op;
        ins.operand_value = val;
        ins.operand_is_number = tag;
        ins.jump_target = tgt;
        instr_ch.data <= ins;
        instr_ch.valid <= 1;
        @(posedge i_clk iff instr_ch.ready);
        sb.note_instr(ins);
    endtask

    // raw opcode send for unknown codes
    task automatic send_raw(logic [4:0] code);
        send_instr(t_op'(code), $urandom, 1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    task automatic drain();
        instr_ch.valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 9);
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        t_op op;
        int  i;
        instr_ch.valid = 0;
        instr_ch.data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: underflows on empty stack, bad counts, edge arithmetic
        send_instr(OP_POP, 0, 1, 0);
        send_instr(OP_ADD, 0, 1, 0);
        send_instr(OP_NOT, 0, 1, 0);
        send_instr(OP_JEZ, 0, 1, 8'hff);
        send_instr(OP_JMP, 0, 1, 8'hff);
        send_instr(OP_POPN, 0, 0, 0);
        send_instr(OP_POPN, 32'hffff_ffff, 1, 0);
        send_instr(OP_POPN, 0, 1, 0);
        send_instr(OP_PUSH, 32'h8000_0000, 1, 0);
        send_instr(OP_PUSH, 32'hffff_ffff, 1, 0);
        send_instr(OP_DIV, 0, 1, 0);           // most negative / -1 wraps
        send_instr(OP_PUSH, 0, 1, 0);
        send_instr(OP_DIV, 0, 1, 0);           // divide by zero
        send_instr(OP_PUSH, 32'h7fff_ffff, 0, 0);
        send_instr(OP_INC, 0, 1, 0);           // non-number: untouched
        send_instr(OP_JNZ, 0, 1, 8'h5a);
        send_instr(OP_MUL, 0, 1, 0);           // non-number operand
        send_raw(5'd31);
        send_raw(5'd18);
        send_instr(OP_POPN, 4, 1, 0);          // count above depth
        send_instr(OP_POPN, 3, 1, 0);
        drain();

        // fill to full and overflow, then empty with popn
        for (i = 0; i < DEPTH; i++) send_instr(OP_PUSH, $urandom, 1, 0, 1);
        send_instr(OP_PUSH, 1, 1, 0);
        send_instr(OP_DUP, 0, 1, 0);
        send_instr(OP_POPN, DEPTH, 1, 0);

        // random: biased toward well-formed sequences on small stacks
        for (i = 0; i < 1400; i++) begin
            if (i == 600) begin
                drain();   // pause until all results are back
                sink_idle_off = 1;
            end
            if (i == 900) sink_idle_off = 0;
            if ($urandom_range(0, 40) == 0) begin
                send_raw(5'($urandom_range(18, 31)));
                continue;
            end
            model_depth = sb.sp;
            if (model_depth < 2 || $urandom_range(0, 3) == 0)
                op = ($urandom_range(0, 4) == 0) ? OP_DUP : OP_PUSH;
            else if (model_depth > 40)
                op = ($urandom_range(0, 1) == 0) ? OP_POPN : OP_ADD;
            else
                op = t_op'($urandom_range(0, 17));
            if (op == OP_RET) op = OP_POP;
            if (op == OP_POPN)
                send_instr(op, ($urandom_range(0, 7) == 0) ? pick_value()
                                                             : $urandom_range(0, model_depth + 1),
                           $urandom_range(0, 15) != 0, 8'($urandom));
            else
                send_instr(op, pick_value(), $urandom_range(0, 9) != 0, 8'($urandom));
        end

        // halt, then everything reports halted
        send_instr(OP_PUSH, $urandom, 1, 0);
        send_instr(OP_RET, 0, 1, 0);
        for (i = 0; i < 18; i++) send_instr(t_op'(i), $urandom, 1, 8'($urandom));
        drain();
        repeat (100) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
